// File: design/wst_pkg.sv
// Shared types and constants for the station table tracker.
// Holds the command struct passed from front to back, status codes and the back-end states.
// No dependencies.
`default_nettype none

package wst_pkg;

   localparam int DEFAULT_MAX_ENTRIES = 16;

   // Depth of the command queue between the front and back ends.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTRW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNTW  = $clog2(QUEUE_DEPTH + 1);

   localparam int ADDR_W = 48;
   localparam int TIME_W = 32;
   localparam int SIG_W  = 8;
   localparam int CNT_W  = 32;

   // Frame classification constants.
   localparam logic [1:0]  KIND_MGMT         = 2'd0;
   localparam logic [1:0]  KIND_DATA         = 2'd1;
   localparam logic [3:0]  SUBTYPE_PROBE_REQ = 4'h4;
   localparam logic [7:0]  TAG_SSID          = 8'd0;
   localparam logic [7:0]  SSID_MAX_LEN      = 8'd32;
   localparam logic [12:0] PROBE_MIN_LEN     = 13'd26;
   localparam logic [11:0] DATA_MIN_LEN      = 12'd24;

   typedef enum logic [1:0] {
      STATUS_IGNORED = 2'd0,
      STATUS_UPDATED = 2'd1,
      STATUS_ADDED   = 2'd2,
      STATUS_FULL    = 2'd3
   } status_type;

   typedef enum logic {
      BACK_IDLE = 1'b0,
      BACK_SCAN = 1'b1
   } back_state_type;

   // One classified frame as it travels from the front end to the back end.
   typedef struct packed {
      logic              act;
      logic              is_data;
      logic [ADDR_W-1:0] sta;
      logic [SIG_W-1:0]  sig;
      logic [TIME_W-1:0] now;
   } cmd_type;

endpackage

`default_nettype wire

// File: design/wst_front.sv
// Front end of the station table tracker: takes frame digests and classifies them.
// Holds the target BSSID register. Depends on wst_pkg.
`default_nettype none

module wst_front import wst_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_frame_kind,
   input  wire logic [11:0]       req_frame_length,
   input  wire logic [7:0]        req_control_low,
   input  wire logic [7:0]        req_control_high,
   input  wire logic [47:0]       req_address_one,
   input  wire logic [47:0]       req_address_two,
   input  wire logic signed [7:0] req_signal_dbm,
   input  wire logic [31:0]       req_now_ms,
   input  wire logic [7:0]        req_tag_ident,
   input  wire logic [7:0]        req_tag_length,
   input  wire logic              req_ssid_printable,
   input  wire logic              csr_write_en,
   input  wire logic [47:0]       csr_target_bssid,
   output logic                   push,
   output cmd_type                push_cmd,
   input  wire logic              queue_full
);

   logic [47:0] target_ff;
   logic        cmd_vld_ff, cmd_vld_in;
   cmd_type     cmd_ff, cmd_in;
   logic        accept;
   logic        probe_ok, data_ok, to_ds, from_ds;
   logic [12:0] probe_need;
   logic [47:0] bss;

   assign req_stall = cmd_vld_ff && queue_full;
   assign accept    = req_valid && !req_stall;
   assign push      = cmd_vld_ff && !queue_full;
   assign push_cmd  = cmd_ff;

   always_comb begin
      probe_need = PROBE_MIN_LEN + {5'b0, req_tag_length};
      to_ds      = req_control_high[0];
      from_ds    = req_control_high[1];
      bss        = to_ds ? req_address_one : req_address_two;

      probe_ok = (req_frame_kind == KIND_MGMT)
              && ({1'b0, req_frame_length} >= PROBE_MIN_LEN)
              && (req_control_low[7:4] == SUBTYPE_PROBE_REQ)
              && (req_tag_ident == TAG_SSID)
              && (req_tag_length != 8'd0)
              && (req_tag_length <= SSID_MAX_LEN)
              && ({1'b0, req_frame_length} >= probe_need)
              && req_ssid_printable;

      data_ok = (req_frame_kind == KIND_DATA)
             && (req_frame_length >= DATA_MIN_LEN)
             && (to_ds ^ from_ds)
             && (bss == target_ff);

      cmd_in.act     = probe_ok || data_ok;
      cmd_in.is_data = data_ok;
      cmd_in.sta     = (data_ok && !to_ds) ? req_address_one : req_address_two;
      cmd_in.sig     = req_signal_dbm;
      cmd_in.now     = req_now_ms;

      cmd_vld_in = (cmd_vld_ff && queue_full) || accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff  <= '0;
         cmd_vld_ff <= 1'b0;
      end else begin
         cmd_vld_ff <= cmd_vld_in;
         if (csr_write_en) begin
            target_ff <= csr_target_bssid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

`default_nettype wire

// File: design/wst_cmd_queue.sv
// Short queue of classified commands between the front and back ends.
// Depends on wst_pkg for the command type and depth.
`default_nettype none

module wst_cmd_queue import wst_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      head,
   output logic         empty
);

   cmd_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTRW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTRW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNTW-1:0]   fill_ff, fill_in;

   assign full  = (fill_ff == QUEUE_CNTW'(QUEUE_DEPTH));
   assign empty = (fill_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTRW'(QUEUE_DEPTH - 1)) ? '0
                                                                : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTRW'(QUEUE_DEPTH - 1)) ? '0
                                                                : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// File: design/wst_back.sv
// Back end of the station table tracker: searches the station table and updates it.
// Owns the station memories, the entry count and the result register. Depends on wst_pkg.
`default_nettype none

module wst_back import wst_pkg::*; #(
   parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    clear,
   input  wire cmd_type head,
   input  wire logic    empty,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output logic [1:0]   rsp_status,
   output logic [3:0]   rsp_entry_index,
   output logic [4:0]   rsp_station_count,
   output logic [31:0]  rsp_frame_total
);

   localparam int IDXW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNTW = $clog2(MAX_ENTRIES + 1);

   // Station memories; entries at or above the count never take part in a match.
   logic [ADDR_W-1:0] addr_mem   [MAX_ENTRIES];
   logic [SIG_W-1:0]  sig_mem    [MAX_ENTRIES];
   logic [TIME_W-1:0] seen_mem   [MAX_ENTRIES];
   logic [CNT_W-1:0]  frames_mem [MAX_ENTRIES];

   back_state_type    state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [CNTW-1:0]   count_ff, count_in;
   logic [CNTW-1:0]   scan_ff, scan_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [IDXW-1:0]   rd_idx_ff;
   logic [ADDR_W-1:0] addr_rd_ff;
   logic [CNT_W-1:0]  frames_rd_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff, status_in;
   logic [IDXW-1:0]   index_ff, index_in;
   logic [CNTW-1:0]   rcount_ff, rcount_in;
   logic [CNT_W-1:0]  total_ff, total_in;

   logic              issue, hit, miss, tab_full, load;
   logic              mem_we;
   logic [IDXW-1:0]   wr_addr;
   logic [CNT_W-1:0]  frames_wd;
   logic [CNTW-1:0]   rd_idx_ext;
   logic [IDXW+3:0]   index_wide;
   logic [CNTW+4:0]   count_wide;

   assign rd_idx_ext = CNTW'(rd_idx_ff);
   assign index_wide = {4'b0, index_ff};
   assign count_wide = {5'b0, rcount_ff};

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_entry_index   = index_wide[3:0];
   assign rsp_station_count = count_wide[4:0];
   assign rsp_frame_total   = total_ff;

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      count_in  = count_ff;
      scan_in   = scan_ff;
      rd_vld_in = 1'b0;
      status_in = status_ff;
      index_in  = index_ff;
      rcount_in = rcount_ff;
      total_in  = total_ff;
      pop       = 1'b0;
      load      = 1'b0;
      mem_we    = 1'b0;
      wr_addr   = rd_idx_ff;
      frames_wd = '0;

      issue    = (scan_ff < count_ff);
      hit      = rd_vld_ff && (addr_rd_ff == cmd_ff.sta);
      miss     = (count_ff == '0)
              || (rd_vld_ff && !hit && (CNTW'(rd_idx_ext + 1'b1) == count_ff));
      tab_full = (count_ff == CNTW'(MAX_ENTRIES));

      case (state_ff)
         BACK_IDLE: begin
            // A new command starts only once the result register has drained.
            if (!empty && !rsp_valid_ff) begin
               pop = 1'b1;
               if (head.act) begin
                  cmd_in   = head;
                  scan_in  = '0;
                  state_in = BACK_SCAN;
               end else begin
                  load      = 1'b1;
                  status_in = STATUS_IGNORED;
                  index_in  = '0;
                  rcount_in = count_ff;
                  total_in  = '0;
               end
            end
         end
         BACK_SCAN: begin
            if (hit) begin
               load      = 1'b1;
               mem_we    = 1'b1;
               wr_addr   = rd_idx_ff;
               frames_wd = frames_rd_ff + {{(CNT_W-1){1'b0}}, cmd_ff.is_data};
               status_in = STATUS_UPDATED;
               index_in  = rd_idx_ff;
               rcount_in = count_ff;
               total_in  = frames_wd;
               state_in  = BACK_IDLE;
            end else if (miss) begin
               load     = 1'b1;
               state_in = BACK_IDLE;
               if (tab_full) begin
                  status_in = STATUS_FULL;
                  index_in  = '0;
                  rcount_in = count_ff;
                  total_in  = '0;
               end else begin
                  mem_we    = 1'b1;
                  wr_addr   = count_ff[IDXW-1:0];
                  frames_wd = {{(CNT_W-1){1'b0}}, cmd_ff.is_data};
                  count_in  = CNTW'(count_ff + 1'b1);
                  status_in = STATUS_ADDED;
                  index_in  = count_ff[IDXW-1:0];
                  rcount_in = CNTW'(count_ff + 1'b1);
                  total_in  = frames_wd;
               end
            end else begin
               rd_vld_in = issue;
               scan_in   = issue ? CNTW'(scan_ff + 1'b1) : scan_ff;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase

      if (clear) begin
         count_in = '0;
      end

      rsp_valid_in = (rsp_valid_ff && rsp_stall) || load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      status_ff <= status_in;
      index_ff  <= index_in;
      rcount_ff <= rcount_in;
      total_ff  <= total_in;
   end

   // Memory read port follows the scan pointer; write port serves the final update.
   always_ff @(posedge clock) begin
      addr_rd_ff   <= addr_mem[scan_ff[IDXW-1:0]];
      frames_rd_ff <= frames_mem[scan_ff[IDXW-1:0]];
      rd_idx_ff    <= scan_ff[IDXW-1:0];
      if (mem_we) begin
         addr_mem[wr_addr]   <= cmd_ff.sta;
         sig_mem[wr_addr]    <= cmd_ff.sig;
         seen_mem[wr_addr]   <= cmd_ff.now;
         frames_mem[wr_addr] <= frames_wd;
      end
   end

endmodule

`default_nettype wire

// File: design/wlan_station_table_tracker_core.sv
// Station table tracker: front end classifies each frame beat, a two-entry queue decouples it
// from the back end, which searches the table one entry per cycle through its memory read port.
// An ignored frame passes the front-end command register and the queue before the back end loads
// its result register; a tracked frame also runs the table scan, whose memory read is registered.
// The back end takes a new beat only once the result register has drained and, after a tracked
// beat, only once its table scan has ended.
// Reset is synchronous, active high: table empty, target BSSID zero, no result pending.
`default_nettype none

module wlan_station_table_tracker_core import wst_pkg::*; #(
   parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // Input channel: one frame digest per beat.
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_frame_kind,
   input  wire logic [11:0]       req_frame_length,
   input  wire logic [7:0]        req_control_low,
   input  wire logic [7:0]        req_control_high,
   input  wire logic [47:0]       req_address_one,
   input  wire logic [47:0]       req_address_two,
   input  wire logic signed [7:0] req_signal_dbm,
   input  wire logic [31:0]       req_now_ms,
   input  wire logic [7:0]        req_tag_ident,
   input  wire logic [7:0]        req_tag_length,
   input  wire logic              req_ssid_printable,
   // Result channel: one result beat per frame beat, in order.
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [1:0]             rsp_status,
   output logic [3:0]             rsp_entry_index,
   output logic [4:0]             rsp_station_count,
   output logic [31:0]            rsp_frame_total,
   // Configuration: writing the target BSSID also empties the table.
   input  wire logic              csr_write_en,
   input  wire logic [47:0]       csr_target_bssid
);

   logic    push, queue_full, pop, queue_empty;
   cmd_type push_cmd, queue_head;

   // The front end registers the classified frame, so a stalled queue never loses a beat.
   wst_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_frame_kind     (req_frame_kind),
      .req_frame_length   (req_frame_length),
      .req_control_low    (req_control_low),
      .req_control_high   (req_control_high),
      .req_address_one    (req_address_one),
      .req_address_two    (req_address_two),
      .req_signal_dbm     (req_signal_dbm),
      .req_now_ms         (req_now_ms),
      .req_tag_ident      (req_tag_ident),
      .req_tag_length     (req_tag_length),
      .req_ssid_printable (req_ssid_printable),
      .csr_write_en       (csr_write_en),
      .csr_target_bssid   (csr_target_bssid),
      .push               (push),
      .push_cmd           (push_cmd),
      .queue_full         (queue_full)
   );

   // The queue lets the front end keep taking beats while the back end is mid-search.
   wst_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .head     (queue_head),
      .empty    (queue_empty)
   );

   // The back end owns the table, so the configuration write clears its entry count.
   wst_back #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .clear             (csr_write_en),
      .head              (queue_head),
      .empty             (queue_empty),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_entry_index   (rsp_entry_index),
      .rsp_station_count (rsp_station_count),
      .rsp_frame_total   (rsp_frame_total)
   );

endmodule

`default_nettype wire
